FILE: rtl/vt3_pkg.sv
// ----------------------------------------------------------------------------
// vt3_pkg
// Shared types, codes and constants of the 3D vertex transform.
// ----------------------------------------------------------------------------
`default_nettype none

package vt3_pkg;

  localparam int COORD_WIDTH_DEF = 12;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int PARAM_WIDTH_DEF = 8;

  localparam int OUT_WIDTH       = 32;
  localparam int MODE_WIDTH      = 3;
  localparam int AXIS_WIDTH      = 2;
  localparam int ANGLE_WIDTH     = 10;
  localparam int CFG_INDEX_WIDTH = 3;

  // Q1.14 trig values; signed word holds -1.0 .. +1.0
  localparam int ROM_FRAC   = 14;
  localparam int TRIG_WIDTH = ROM_FRAC + 2;
  localparam int ROM_ONE    = 1 << ROM_FRAC;
  localparam int ROM_DEPTH  = 91;

  localparam int DEG_QUARTER = 90;
  localparam int DEG_TURN    = 360;

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_TRANSLATE = 3'd0,
    MODE_SCALE     = 3'd1,
    MODE_ROTATE    = 3'd2,
    MODE_REFLECT   = 3'd3,
    MODE_SHEAR     = 3'd4
  } vt3_mode_t;

  // Rotation axis; the same codes select the reflection plane XY, YZ, XZ
  typedef enum logic [AXIS_WIDTH-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } vt3_axis_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MODE    = 3'd0,
    REG_AXIS    = 3'd1,
    REG_ANGLE   = 3'd2,
    REG_PARAM_A = 3'd3,
    REG_PARAM_B = 3'd4,
    REG_PARAM_C = 3'd5
  } vt3_reg_t;

  typedef struct packed {
    logic [MODE_WIDTH-1:0]        mode;
    logic [AXIS_WIDTH-1:0]        axis;
    logic signed [TRIG_WIDTH-1:0] sin_val;
    logic signed [TRIG_WIDTH-1:0] cos_val;
  } vt3_ctrl_t;

  // round(16384 * sin(d degrees)), d = 0 .. 90
  localparam logic [ROM_FRAC:0] SIN_ROM [ROM_DEPTH] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
    15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
    15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
    15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
    15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
    15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
    15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
    15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
    15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
    15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
    15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
    15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
    15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
    15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
    15'd16384
  };

endpackage

`default_nettype wire

FILE: rtl/vt3_in_if.sv
// ----------------------------------------------------------------------------
// vt3_in_if
// Vertex input channel: valid/ready handshake with integer coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface vt3_in_if #(
  parameter int COORD_WIDTH = vt3_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_in;
  logic signed [COORD_WIDTH-1:0] y_in;
  logic signed [COORD_WIDTH-1:0] z_in;

  modport source (output valid, x_in, y_in, z_in, input ready);
  modport sink   (input valid, x_in, y_in, z_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/vt3_out_if.sv
// ----------------------------------------------------------------------------
// vt3_out_if
// Vertex result channel: valid/ready handshake with fixed-point coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface vt3_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [vt3_pkg::OUT_WIDTH-1:0] x_out;
  logic signed [vt3_pkg::OUT_WIDTH-1:0] y_out;
  logic signed [vt3_pkg::OUT_WIDTH-1:0] z_out;

  modport source (output valid, x_out, y_out, z_out, input ready);
  modport sink   (input valid, x_out, y_out, z_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/vertex_transform_3d.sv
// ----------------------------------------------------------------------------
// vertex_transform_3d
// Affine transform of one integer vertex per clock, while out_vtx is ready, into Q.FRAC_BITS output.
//
// Usage:
//  - in_vtx carries x_in, y_in, z_in; a transaction completes when valid and
//    ready are both high at a rising edge of clk.
//  - out_vtx returns x_out, y_out, z_out (32-bit, FRAC_BITS fraction bits,
//    wrapped) under the same handshake, one result per input, in order.
//  - cfg_we/cfg_index/cfg_data write mode, axis, angle, param_a/b/c; write
//    only while no vertex is in flight. An angle write converts the angle to
//    sine and cosine in the same cycle.
//  - Path: a vertex accepted at an edge sits in the input register, then moves
//    to the result register, from which it is offered on out_vtx.
//  - Throughput: one vertex per clock, held only by out_vtx.ready.
//  - A stalled receiver holds the result register; the input register fills
//    behind it and in_vtx.ready drops once both are occupied.
//  - Synchronous reset empties the pipeline and returns the configuration
//    registers to zero, cosine to one (identity), which selects translation by zero.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_3d #(
  parameter int COORD_WIDTH     = vt3_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS       = vt3_pkg::FRAC_BITS_DEF,
  parameter int PARAM_WIDTH     = vt3_pkg::PARAM_WIDTH_DEF,
  localparam int CFG_DATA_WIDTH = (PARAM_WIDTH > vt3_pkg::ANGLE_WIDTH) ?
                                  PARAM_WIDTH : vt3_pkg::ANGLE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  vt3_in_if.sink                              in_vtx,
  vt3_out_if.source                           out_vtx,
  input  logic                                cfg_we,
  input  logic [vt3_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]           cfg_data
);
  import vt3_pkg::*;

  vt3_ctrl_t                     ctrl;
  logic signed [PARAM_WIDTH-1:0] param_a;
  logic signed [PARAM_WIDTH-1:0] param_b;
  logic signed [PARAM_WIDTH-1:0] param_c;

  // registers and angle conversion
  vt3_cfg #(
    .PARAM_WIDTH    (PARAM_WIDTH),
    .CFG_DATA_WIDTH (CFG_DATA_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .param_a   (param_a),
    .param_b   (param_b),
    .param_c   (param_c)
  );

  // single-pass transform datapath
  vt3_core #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .PARAM_WIDTH (PARAM_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_vtx.valid),
    .in_ready  (in_vtx.ready),
    .x_in      (COORD_WIDTH'(in_vtx.x_in)),
    .y_in      (COORD_WIDTH'(in_vtx.y_in)),
    .z_in      (COORD_WIDTH'(in_vtx.z_in)),
    .out_valid (out_vtx.valid),
    .out_ready (out_vtx.ready),
    .x_out     (out_vtx.x_out),
    .y_out     (out_vtx.y_out),
    .z_out     (out_vtx.z_out),
    .ctrl      (ctrl),
    .param_a   (param_a),
    .param_b   (param_b),
    .param_c   (param_c)
  );

endmodule

`default_nettype wire

FILE: rtl/vt3_cfg.sv
// ----------------------------------------------------------------------------
// vt3_cfg
// Configuration registers; converts the angle to sine and cosine on write.
// ----------------------------------------------------------------------------
`default_nettype none

module vt3_cfg #(
  parameter int PARAM_WIDTH    = vt3_pkg::PARAM_WIDTH_DEF,
  parameter int CFG_DATA_WIDTH = vt3_pkg::ANGLE_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [vt3_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]              cfg_data,
  output vt3_pkg::vt3_ctrl_t                     ctrl,
  output logic signed [PARAM_WIDTH-1:0]          param_a,
  output logic signed [PARAM_WIDTH-1:0]          param_b,
  output logic signed [PARAM_WIDTH-1:0]          param_c
);
  import vt3_pkg::*;

  localparam int AW      = ANGLE_WIDTH + 1;
  localparam int DEG_W   = 9;
  localparam int REM_W   = 7;

  logic [MODE_WIDTH-1:0]        mode_r;
  logic [AXIS_WIDTH-1:0]        axis_r;
  logic signed [TRIG_WIDTH-1:0] sin_r;
  logic signed [TRIG_WIDTH-1:0] cos_r;
  logic signed [PARAM_WIDTH-1:0] pa_r;
  logic signed [PARAM_WIDTH-1:0] pb_r;
  logic signed [PARAM_WIDTH-1:0] pc_r;

  logic signed [AW-1:0]         ang_ext;
  logic signed [AW-1:0]         ang_wrap1;
  logic signed [AW-1:0]         ang_wrap2;
  logic [DEG_W-1:0]             deg;
  logic [1:0]                   quad;
  logic [REM_W-1:0]             rem_deg;
  logic [ROM_FRAC:0]            rom_lo;
  logic [ROM_FRAC:0]            rom_hi;
  logic signed [TRIG_WIDTH-1:0] lo_s;
  logic signed [TRIG_WIDTH-1:0] hi_s;
  logic signed [TRIG_WIDTH-1:0] sin_nxt;
  logic signed [TRIG_WIDTH-1:0] cos_nxt;

  // reduce the angle into 0 .. 359
  assign ang_ext   = AW'(signed'(cfg_data[ANGLE_WIDTH-1:0]));
  assign ang_wrap1 = ang_ext[AW-1] ? ang_ext + AW'(DEG_TURN) : ang_ext;
  assign ang_wrap2 = ang_wrap1[AW-1] ? ang_wrap1 + AW'(DEG_TURN) : ang_wrap1;
  assign deg       = (ang_wrap2 >= AW'(DEG_TURN)) ? DEG_W'(ang_wrap2 - AW'(DEG_TURN))
                                                  : DEG_W'(ang_wrap2);

  always_comb begin
    priority if (deg >= DEG_W'(3 * DEG_QUARTER)) begin
      quad    = 2'd3;
      rem_deg = REM_W'(deg - DEG_W'(3 * DEG_QUARTER));
    end else if (deg >= DEG_W'(2 * DEG_QUARTER)) begin
      quad    = 2'd2;
      rem_deg = REM_W'(deg - DEG_W'(2 * DEG_QUARTER));
    end else if (deg >= DEG_W'(DEG_QUARTER)) begin
      quad    = 2'd1;
      rem_deg = REM_W'(deg - DEG_W'(DEG_QUARTER));
    end else begin
      quad    = 2'd0;
      rem_deg = REM_W'(deg);
    end
  end

  assign rom_lo = SIN_ROM[rem_deg];
  assign rom_hi = SIN_ROM[REM_W'(DEG_QUARTER) - rem_deg];
  assign lo_s   = signed'(TRIG_WIDTH'(rom_lo));
  assign hi_s   = signed'(TRIG_WIDTH'(rom_hi));

  // cosine is the sine one quadrant on
  always_comb begin
    unique case (quad)
      2'd0: begin
        sin_nxt = lo_s;
        cos_nxt = hi_s;
      end
      2'd1: begin
        sin_nxt = hi_s;
        cos_nxt = -lo_s;
      end
      2'd2: begin
        sin_nxt = -lo_s;
        cos_nxt = -hi_s;
      end
      default: begin
        sin_nxt = -hi_s;
        cos_nxt = lo_s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      axis_r <= '0;
      sin_r  <= '0;
      cos_r  <= TRIG_WIDTH'(ROM_ONE);
      pa_r   <= '0;
      pb_r   <= '0;
      pc_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:    mode_r <= cfg_data[MODE_WIDTH-1:0];
        REG_AXIS:    axis_r <= cfg_data[AXIS_WIDTH-1:0];
        REG_ANGLE: begin
          sin_r <= sin_nxt;
          cos_r <= cos_nxt;
        end
        REG_PARAM_A: pa_r <= signed'(cfg_data[PARAM_WIDTH-1:0]);
        REG_PARAM_B: pb_r <= signed'(cfg_data[PARAM_WIDTH-1:0]);
        REG_PARAM_C: pc_r <= signed'(cfg_data[PARAM_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

  assign ctrl.mode    = mode_r;
  assign ctrl.axis    = axis_r;
  assign ctrl.sin_val = sin_r;
  assign ctrl.cos_val = cos_r;
  assign param_a      = pa_r;
  assign param_b      = pb_r;
  assign param_c      = pc_r;

  a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == REG_MODE) |=> mode_r == $past(cfg_data[MODE_WIDTH-1:0]))
    else $error("mode register did not take the written value");

  a_angle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == REG_ANGLE && cfg_data[ANGLE_WIDTH-1:0] == '0)
    |=> (sin_r == '0 && cos_r == TRIG_WIDTH'(ROM_ONE)))
    else $error("zero angle gave wrong sine or cosine");

  a_angle_right: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == REG_ANGLE
     && cfg_data[ANGLE_WIDTH-1:0] == ANGLE_WIDTH'(DEG_QUARTER))
    |=> (sin_r == TRIG_WIDTH'(ROM_ONE) && cos_r == '0))
    else $error("right angle gave wrong sine or cosine");

endmodule

`default_nettype wire

FILE: rtl/vt3_core.sv
// ----------------------------------------------------------------------------
// vt3_core
// Single-pass datapath: input register, combinational transform, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vt3_core #(
  parameter int COORD_WIDTH = vt3_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = vt3_pkg::FRAC_BITS_DEF,
  parameter int PARAM_WIDTH = vt3_pkg::PARAM_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH-1:0]         x_in,
  input  logic signed [COORD_WIDTH-1:0]         y_in,
  input  logic signed [COORD_WIDTH-1:0]         z_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [vt3_pkg::OUT_WIDTH-1:0]  x_out,
  output logic signed [vt3_pkg::OUT_WIDTH-1:0]  y_out,
  output logic signed [vt3_pkg::OUT_WIDTH-1:0]  z_out,
  input  vt3_pkg::vt3_ctrl_t                    ctrl,
  input  logic signed [PARAM_WIDTH-1:0]         param_a,
  input  logic signed [PARAM_WIDTH-1:0]         param_b,
  input  logic signed [PARAM_WIDTH-1:0]         param_c
);
  import vt3_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int OW    = OUT_WIDTH;
  localparam int SCL_W = COORD_WIDTH + PARAM_WIDTH;
  localparam int ROT_W = COORD_WIDTH + TRIG_WIDTH;
  localparam int SUM_W = ROT_W + 1;
  localparam int RND_W = SUM_W + 1;

  function automatic logic signed [OW-1:0] to_fix(input logic signed [OW-1:0] v);
    return v <<< FRAC_BITS;
  endfunction

  // handshake: a register advances when empty or when the next one advances
  logic v1_r, v2_r;
  logic adv1, adv2;

  assign adv2     = !v2_r || out_ready;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  // input register
  logic signed [CW-1:0] x1_r, y1_r, z1_r;

  // products of the held vertex
  logic signed [CW-1:0]    u_sel, v_sel;
  logic signed [SCL_W-1:0] xa_prod, yb_prod, zc_prod;
  logic signed [ROT_W-1:0] uc_prod, vs_prod, vc_prod, us_prod;

  // combine, round and register
  logic signed [SUM_W-1:0] ru_sum, rv_sum;
  logic signed [OW-1:0]    ru_q, rv_q;
  logic signed [OW-1:0]    xi, yi, zi;
  logic signed [OW-1:0]    rx_nxt, ry_nxt, rz_nxt;
  logic signed [OW-1:0]    rx_r, ry_r, rz_r;

  always_comb begin
    unique case (ctrl.axis)
      AXIS_X: begin
        u_sel = y1_r;
        v_sel = z1_r;
      end
      AXIS_Y: begin
        u_sel = x1_r;
        v_sel = z1_r;
      end
      default: begin
        u_sel = x1_r;
        v_sel = y1_r;
      end
    endcase
  end

  assign xa_prod = SCL_W'(x1_r) * SCL_W'(param_a);
  assign yb_prod = SCL_W'(y1_r) * SCL_W'(param_b);
  assign zc_prod = SCL_W'(z1_r) * SCL_W'(param_c);
  assign uc_prod = ROT_W'(u_sel) * ROT_W'(ctrl.cos_val);
  assign vs_prod = ROT_W'(v_sel) * ROT_W'(ctrl.sin_val);
  assign vc_prod = ROT_W'(v_sel) * ROT_W'(ctrl.cos_val);
  assign us_prod = ROT_W'(u_sel) * ROT_W'(ctrl.sin_val);

  // about Z the sine term swaps sign relative to X and Y
  always_comb begin
    if (ctrl.axis == AXIS_Z) begin
      ru_sum = SUM_W'(uc_prod) - SUM_W'(vs_prod);
      rv_sum = SUM_W'(vc_prod) + SUM_W'(us_prod);
    end else begin
      ru_sum = SUM_W'(uc_prod) + SUM_W'(vs_prod);
      rv_sum = SUM_W'(vc_prod) - SUM_W'(us_prod);
    end
  end

  generate
    if (FRAC_BITS < ROM_FRAC) begin : g_round
      localparam int RND_SHIFT = ROM_FRAC - FRAC_BITS;
      localparam int RND_HALF  = 1 << (RND_SHIFT - 1);
      logic signed [RND_W-1:0] ru_rnd, rv_rnd;
      assign ru_rnd = RND_W'(ru_sum) + RND_W'(RND_HALF);
      assign rv_rnd = RND_W'(rv_sum) + RND_W'(RND_HALF);
      assign ru_q   = OW'(ru_rnd >>> RND_SHIFT);
      assign rv_q   = OW'(rv_rnd >>> RND_SHIFT);
    end else begin : g_widen
      localparam int WIDEN = FRAC_BITS - ROM_FRAC;
      assign ru_q = OW'(ru_sum) <<< WIDEN;
      assign rv_q = OW'(rv_sum) <<< WIDEN;
    end
  endgenerate

  assign xi = to_fix(OW'(x1_r));
  assign yi = to_fix(OW'(y1_r));
  assign zi = to_fix(OW'(z1_r));

  always_comb begin
    rx_nxt = xi;
    ry_nxt = yi;
    rz_nxt = zi;
    unique case (ctrl.mode)
      MODE_TRANSLATE: begin
        rx_nxt = to_fix(OW'(x1_r) + OW'(param_a));
        ry_nxt = to_fix(OW'(y1_r) + OW'(param_b));
        rz_nxt = to_fix(OW'(z1_r) + OW'(param_c));
      end
      MODE_SCALE: begin
        rx_nxt = to_fix(OW'(xa_prod));
        ry_nxt = to_fix(OW'(yb_prod));
        rz_nxt = to_fix(OW'(zc_prod));
      end
      MODE_ROTATE: begin
        unique case (ctrl.axis)
          AXIS_X: begin
            ry_nxt = ru_q;
            rz_nxt = rv_q;
          end
          AXIS_Y: begin
            rx_nxt = ru_q;
            rz_nxt = rv_q;
          end
          AXIS_Z: begin
            rx_nxt = ru_q;
            ry_nxt = rv_q;
          end
          default: ;
        endcase
      end
      MODE_REFLECT: begin
        unique case (ctrl.axis)
          AXIS_X:  rz_nxt = -zi;
          AXIS_Y:  rx_nxt = -xi;
          AXIS_Z:  ry_nxt = -yi;
          default: ;
        endcase
      end
      MODE_SHEAR: begin
        ry_nxt = to_fix(OW'(y1_r) + OW'(zc_prod));
        rz_nxt = to_fix(OW'(xa_prod) + OW'(yb_prod) + OW'(z1_r));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      x1_r <= x_in;
      y1_r <= y_in;
      z1_r <= z_in;
    end
    if (adv2) begin
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
      rz_r <= rz_nxt;
    end
  end

  assign out_valid = v2_r;
  assign x_out     = rx_r;
  assign y_out     = ry_r;
  assign z_out     = rz_r;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted vertex not held in the input register");

  a_result_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && adv2) |=> out_valid)
    else $error("vertex lost between input and result registers");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready)
    |=> (out_valid && $stable(x_out) && $stable(y_out) && $stable(z_out)))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !v1_r))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
